// ----- rtl/ihp_pkg.sv -----
// ----------------------------------------------------------------------------
// ihp_pkg: shared types and constants of the Intel HEX record parser
// Character and result item layouts, parse phases, record types, hex decode.
// ----------------------------------------------------------------------------
package ihp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] HEX_TEN      = 8'h0A;

  // Record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_LINEAR  = 8'h04;

  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_SKIP       = 3'd1,
    PH_COUNT      = 3'd2,
    PH_ADDR       = 3'd3,
    PH_TYPE       = 3'd4,
    PH_DATA       = 3'd5,
    PH_CHECK      = 3'd6,
    PH_TAIL       = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_CHECKSUM  = 2'd1,
    KIND_SUMMARY   = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } char_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [31:0] entry_point;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic        range_valid;
    logic        failed;
    logic [15:0] line_number;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      h.ok = 1'b1;
      d    = c - CHAR_DIGIT_0;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      h.ok = 1'b1;
      d    = c - CHAR_UPPER_A + HEX_TEN;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      h.ok = 1'b1;
      d    = c - CHAR_LOWER_A + HEX_TEN;
    end
    h.value = d[3:0];
    return h;
  endfunction

endpackage

// ----- rtl/ihp_if.sv -----
// ----------------------------------------------------------------------------
// ihp_if: valid/ready channels of the Intel HEX record parser
// One channel for text characters, one for result items.
// ----------------------------------------------------------------------------
interface ihp_char_if import ihp_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ihp_result_if import ihp_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ihp_parser.sv -----
// ----------------------------------------------------------------------------
// ihp_parser: record parse state and per-character update
// Advances the record state by one character and forms at most one result.
// ----------------------------------------------------------------------------
module ihp_parser import ihp_pkg::*; #(
  parameter int ADDR_WIDTH       = 32,
  parameter int LINE_COUNT_WIDTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  char_t   char_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam int AW = ADDR_WIDTH;
  localparam int LW = LINE_COUNT_WIDTH;

  phase_e          phase_q, phase_d;
  logic [2:0]      nib_q, nib_d;
  logic [31:0]     field_q, field_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      left_q, left_d;
  logic [7:0]      rkind_q, rkind_d;
  logic [AW-1:0]   seg_q, seg_d;
  logic [AW-1:0]   waddr_q, waddr_d;
  logic [7:0]      sum_q, sum_d;
  logic [AW-1:0]   low_q, low_d;
  logic [AW-1:0]   high_q, high_d;
  logic            any_q, any_d;
  logic [31:0]     entry_q, entry_d;
  logic [LW-1:0]   line_q, line_d;
  logic            stop_q, stop_d;

  hex_t        hex;
  logic [31:0] fv_n;
  logic [2:0]  nib_n;
  logic        act, hex_phase, bad, dig, field_end, last_byte, fin, do_write;
  logic [7:0]  sum_n;
  logic [31:0] fin_value;
  logic [31:0] line_wide;

  assign hex       = hex_decode(char_i.char_code);
  assign fv_n      = {field_q[27:0], hex.value};
  assign nib_n     = nib_q + 3'd1;
  assign act       = step_i && !char_i.end_of_stream && !stop_q;
  assign hex_phase = (phase_q inside {PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK});
  assign bad       = act && hex_phase && !hex.ok;
  assign dig       = act && hex_phase && hex.ok;
  assign field_end = dig && ((phase_q == PH_ADDR) ? (nib_n == 3'd4) : (nib_n == 3'd2));
  assign last_byte = field_end && (phase_q == PH_DATA) && (left_q == 8'd1);
  assign fin       = (field_end && (phase_q == PH_TYPE) && (len_q == 8'd0)) || last_byte;
  assign do_write  = field_end && (phase_q == PH_DATA) && (rkind_q == REC_DATA);
  assign sum_n     = (phase_q == PH_ADDR) ? (sum_q + fv_n[15:8] + fv_n[7:0])
                                          : (sum_q + fv_n[7:0]);
  // A record with no data bytes ends with a zero value
  assign fin_value = (phase_q == PH_DATA) ? fv_n : 32'd0;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (act) begin
      unique case (phase_q)
        PH_LINE_START: begin
          if (char_i.char_code == CHAR_COLON) begin
            phase_d = PH_COUNT;
          end else if (char_i.char_code != CHAR_NEWLINE) begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP, PH_TAIL: begin
          if (char_i.char_code == CHAR_NEWLINE) begin
            phase_d = PH_LINE_START;
          end
        end
        default: begin
          if (bad) begin
            phase_d = (char_i.char_code == CHAR_NEWLINE) ? PH_LINE_START : PH_SKIP;
          end else if (field_end) begin
            unique case (phase_q)
              PH_COUNT: phase_d = PH_ADDR;
              PH_ADDR:  phase_d = PH_TYPE;
              PH_TYPE:  phase_d = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
              PH_DATA:  phase_d = last_byte ? PH_CHECK : PH_DATA;
              default:  phase_d = (sum_n == 8'd0) ? PH_TAIL : PH_CHECK;
            endcase
          end
        end
      endcase
    end
  end

  // Datapath state
  always_comb begin
    nib_d   = nib_q;
    field_d = field_q;
    len_d   = len_q;
    left_d  = left_q;
    rkind_d = rkind_q;
    seg_d   = seg_q;
    waddr_d = waddr_q;
    sum_d   = sum_q;
    low_d   = low_q;
    high_d  = high_q;
    any_d   = any_q;
    entry_d = entry_q;
    line_d  = line_q;
    stop_d  = stop_q;

    if (act && phase_q == PH_LINE_START) begin
      if (line_q != '1) begin
        line_d = line_q + LW'(1);
      end
      if (char_i.char_code == CHAR_COLON) begin
        nib_d   = '0;
        field_d = '0;
        sum_d   = '0;
      end
    end

    if (dig) begin
      nib_d   = nib_n;
      field_d = fv_n;
      if (field_end) begin
        nib_d   = '0;
        field_d = '0;
        sum_d   = sum_n;
        unique case (phase_q)
          PH_COUNT: len_d = fv_n[7:0];
          PH_ADDR:  waddr_d = seg_q + AW'(fv_n[15:0]);
          PH_TYPE: begin
            rkind_d = fv_n[7:0];
            left_d  = len_q;
          end
          PH_DATA: begin
            // Keep the shifted bytes: start and base values come from them
            field_d = fv_n;
            waddr_d = waddr_q + AW'(1);
            left_d  = left_q - 8'd1;
            if (do_write) begin
              any_d = 1'b1;
              if (!any_q || waddr_q < low_q) begin
                low_d = waddr_q;
              end
              if (!any_q || waddr_q > high_q) begin
                high_d = waddr_q;
              end
            end
          end
          default: begin
            if (sum_n != 8'd0) begin
              stop_d = 1'b1;
            end
          end
        endcase
      end
    end

    if (fin) begin
      nib_d   = '0;
      field_d = '0;
      if (phase_q == PH_TYPE) begin
        rkind_d = fv_n[7:0];
      end
      if ((phase_q == PH_TYPE ? fv_n[7:0] : rkind_q) == REC_EOF) begin
        entry_d = fin_value;
      end else if ((phase_q == PH_TYPE ? fv_n[7:0] : rkind_q) == REC_SEGMENT) begin
        seg_d = AW'({fin_value[15:0], 4'h0});
      end else if ((phase_q == PH_TYPE ? fv_n[7:0] : rkind_q) == REC_LINEAR) begin
        seg_d = AW'({fin_value[15:0], 16'h0000});
      end
    end
  end

  // Result item, taken from the updated state
  assign line_wide = 32'(line_d);

  always_comb begin
    res_valid_o         = 1'b0;
    res_o.result_kind   = KIND_SUMMARY;
    res_o.write_address = '0;
    res_o.write_data    = '0;
    if (step_i && char_i.end_of_stream) begin
      res_valid_o       = 1'b1;
      res_o.result_kind = KIND_SUMMARY;
    end else if (bad) begin
      res_valid_o       = 1'b1;
      res_o.result_kind = KIND_MALFORMED;
    end else if (do_write) begin
      res_valid_o         = 1'b1;
      res_o.result_kind   = KIND_WRITE;
      res_o.write_address = 32'(waddr_q);
      res_o.write_data    = fv_n[7:0];
    end else if (field_end && phase_q == PH_CHECK && sum_n != 8'd0) begin
      res_valid_o       = 1'b1;
      res_o.result_kind = KIND_CHECKSUM;
    end
    res_o.entry_point = entry_d;
    res_o.range_low   = any_d ? 32'(low_d) : 32'd0;
    res_o.range_high  = any_d ? 32'(high_d) : 32'd0;
    res_o.range_valid = any_d;
    res_o.failed      = stop_d;
    res_o.line_number = (line_wide > 32'h0000_FFFF) ? 16'hFFFF : line_wide[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE_START;
      nib_q   <= '0;
      field_q <= '0;
      len_q   <= '0;
      left_q  <= '0;
      rkind_q <= '0;
      seg_q   <= '0;
      waddr_q <= '0;
      sum_q   <= '0;
      low_q   <= '0;
      high_q  <= '0;
      any_q   <= 1'b0;
      entry_q <= '0;
      line_q  <= '0;
      stop_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      field_q <= field_d;
      len_q   <= len_d;
      left_q  <= left_d;
      rkind_q <= rkind_d;
      seg_q   <= seg_d;
      waddr_q <= waddr_d;
      sum_q   <= sum_d;
      low_q   <= low_d;
      high_q  <= high_d;
      any_q   <= any_d;
      entry_q <= entry_d;
      line_q  <= line_d;
      stop_q  <= stop_d;
    end
  end

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("parser left the stopped state");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.result_kind == KIND_WRITE) |->
      (res_o.range_valid && res_o.range_low <= res_o.write_address &&
       res_o.write_address <= res_o.range_high))
    else $error("write address outside tracked range");

  a_quiet_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && stop_q && !char_i.end_of_stream) |-> !res_valid_o)
    else $error("result produced after checksum failure");

endmodule

// ----- rtl/ihp_out_stage.sv -----
// ----------------------------------------------------------------------------
// ihp_out_stage: result register of the Intel HEX record parser
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module ihp_out_stage import ihp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  result_t          res_i,
  output logic             can_load_o,
  ihp_result_if.source     out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign can_load_o = !valid_q || out_o.ready;
  assign valid_d    = can_load_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

// ----- rtl/intel_hex_record_parser.sv -----
// ----------------------------------------------------------------------------
// intel_hex_record_parser: Intel HEX text stream to memory writes
// Character register, combinational parse update, result register.
// ----------------------------------------------------------------------------
// The block takes one text character per cycle while the sink takes every
// result, and then keeps up with a stream that never pauses: a character is
// registered, the parser updates its record state from the held character
// while any result lands in the output register at that same edge, and the
// result is offered from there. The input stalls only while a character is held
// and the output register still holds an item the sink has not taken.
// The rate of one item per cycle is set by the combinational parse
// update (nibble shift, 8-bit checksum add and the low/high address compare).
// Lines that do not open with ':' are skipped; data records produce one write
// item per byte at base plus address; types 2 and 4 load the segment or
// linear base, type 1 loads the start address. A bad hex digit yields a
// malformed item; a checksum failure yields a failure item and freezes the
// parser until reset. An end_of_stream item always yields a summary item
// carrying the current start address, written range and line number.
// ----------------------------------------------------------------------------
module intel_hex_record_parser import ihp_pkg::*; #(
  parameter int ADDR_WIDTH       = 32,
  parameter int LINE_COUNT_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ihp_char_if.sink      in_i,
  ihp_result_if.source  out_o
);

  logic    in_valid_q, in_valid_d;
  char_t   in_data_q;
  logic    advance;
  logic    out_can_load;
  logic    res_valid;
  result_t res;

  // Advance the held character when the result register can take its result
  assign advance    = in_valid_q && out_can_load;
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the character item on accept
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
  end

  ihp_parser #(
    .ADDR_WIDTH       (ADDR_WIDTH),
    .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .char_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ihp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .can_load_o (out_can_load),
    .out_o      (out_o)
  );

  a_ready_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_o.valid && !out_o.ready))
    else $error("input stalled without a blocked result");

endmodule
